// ===== src/sfr_pkg.sv =====
// Shared types and constants for the supervisory frame receiver.
`default_nettype none

package sfr_pkg;

    // Widths of the byte path and the code kind.
    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int NUM_CODES = 5;
    localparam int CFG_IDX_W = 3;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef byte_t [NUM_CODES-1:0] code_set_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_FLAG       = 3'd0;
    localparam cfg_idx_t REG_ADDRESS    = 3'd1;
    localparam cfg_idx_t REG_READY0     = 3'd2;
    localparam cfg_idx_t REG_READY1     = 3'd3;
    localparam cfg_idx_t REG_REJECT0    = 3'd4;
    localparam cfg_idx_t REG_REJECT1    = 3'd5;
    localparam cfg_idx_t REG_DISCONNECT = 3'd6;

    // Reset values of the configuration registers.
    localparam byte_t RST_FLAG       = 8'd126;
    localparam byte_t RST_ADDRESS    = 8'd3;
    localparam byte_t RST_READY0     = 8'd5;
    localparam byte_t RST_READY1     = 8'd133;
    localparam byte_t RST_REJECT0    = 8'd1;
    localparam byte_t RST_REJECT1    = 8'd129;
    localparam byte_t RST_DISCONNECT = 8'd11;

    // Control code kinds as reported on the result channel.
    localparam kind_t KIND_READY0     = 3'd0;
    localparam kind_t KIND_READY1     = 3'd1;
    localparam kind_t KIND_REJECT0    = 3'd2;
    localparam kind_t KIND_REJECT1    = 3'd3;
    localparam kind_t KIND_DISCONNECT = 3'd4;

    // Control code reported with a timeout.
    localparam byte_t TIMEOUT_CODE = 8'd255;

    // Parser position within the frame.
    typedef enum logic [2:0] {
        ST_HUNT    = 3'd0,
        ST_ADDRESS = 3'd1,
        ST_CONTROL = 3'd2,
        ST_CHECK   = 3'd3,
        ST_CLOSE   = 3'd4
    } parse_state_t;

    // Result of comparing a byte against the accepted control codes.
    typedef struct packed {
        logic  hit;
        kind_t kind;
    } code_match_t;

endpackage

`default_nettype wire

// ===== src/sfr_code_match.sv =====
// Compares a received byte against the five accepted control codes.
`default_nettype none

module sfr_code_match (
    input  wire sfr_pkg::byte_t     rx_byte,
    input  wire sfr_pkg::code_set_t codes,
    output sfr_pkg::code_match_t    match
);
    import sfr_pkg::*;

    // Walk from the highest kind down so that the lowest matching kind wins.
    always_comb
    begin
        match.hit  = 1'b0;
        match.kind = KIND_READY0;
        for (int k = NUM_CODES - 1; k >= 0; k--)
        begin
            if (rx_byte == codes[k])
            begin
                match.hit  = 1'b1;
                match.kind = kind_t'(k);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/supervisory_frame_receiver.sv =====
// Top level of the supervisory frame receiver: byte parser and result register.
//
// Usage: received bytes enter on the input channel (in_valid, in_stall,
// rx_byte, abort), one byte per transfer. Every input transfer produces
// exactly one result transfer on the output channel (out_valid, out_stall,
// frame_ok, control_code, code_kind, timed_out). A result is valid in the
// cycle after its byte is taken; the parser updates its state at the same
// edge, so one byte per cycle is sustained as long as results are taken.
// The parser state machine and the single result register set that figure.
// When the receiver holds out_stall high with a result waiting, in_stall
// rises in the same cycle and the result holds until it is taken; a
// transfer on both sides in one cycle keeps the stream moving.
// An input with abort high clears the parser and reports a timeout with
// control code 255. Configuration writes through cfg_we, cfg_index and
// cfg_data take effect at the next edge; unknown indexes are ignored.
// Reset sets the registers to their default codes, the parser to flag
// hunting and leaves the output channel empty.
`default_nettype none

module supervisory_frame_receiver (
    input  wire                    clk,
    input  wire                    rst_n,
    // Configuration write port
    input  wire                    cfg_we,
    input  wire sfr_pkg::cfg_idx_t cfg_index,
    input  wire sfr_pkg::byte_t    cfg_data,
    // Input channel
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire sfr_pkg::byte_t    rx_byte,
    input  wire                    abort,
    // Output channel
    output logic                   out_valid,
    input  wire                    out_stall,
    output logic                   frame_ok,
    output sfr_pkg::byte_t         control_code,
    output sfr_pkg::kind_t         code_kind,
    output logic                   timed_out
);
    import sfr_pkg::*;

    byte_t        flag_reg;
    byte_t        address_reg;
    code_set_t    codes_reg;

    parse_state_t state_reg, state_next;
    byte_t        held_control_reg, held_control_next;
    kind_t        held_kind_reg, held_kind_next;

    logic         out_valid_reg;
    logic         frame_ok_reg, frame_ok_next;
    byte_t        control_code_reg, control_code_next;
    kind_t        code_kind_reg, code_kind_next;
    logic         timed_out_reg, timed_out_next;

    logic         in_xfer;
    code_match_t  match;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg    <= RST_FLAG;
            address_reg <= RST_ADDRESS;
            codes_reg   <= {RST_DISCONNECT, RST_REJECT1, RST_REJECT0,
                            RST_READY1, RST_READY0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLAG:       flag_reg     <= cfg_data;
                REG_ADDRESS:    address_reg  <= cfg_data;
                REG_READY0:     codes_reg[0] <= cfg_data;
                REG_READY1:     codes_reg[1] <= cfg_data;
                REG_REJECT0:    codes_reg[2] <= cfg_data;
                REG_REJECT1:    codes_reg[3] <= cfg_data;
                REG_DISCONNECT: codes_reg[4] <= cfg_data;
                default:        ;
            endcase
        end
    end

    // The input is taken whenever the result register is empty or drains now.
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    sfr_code_match u_code_match (
        .rx_byte (rx_byte),
        .codes   (codes_reg),
        .match   (match)
    );

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_HUNT;
            held_control_reg <= '0;
            held_kind_reg    <= KIND_READY0;
        end
        else if (in_xfer)
        begin
            state_reg        <= state_next;
            held_control_reg <= held_control_next;
            held_kind_reg    <= held_kind_next;
        end
    end

    // Next parser state and the result of the current byte.
    always_comb
    begin
        state_next        = ST_HUNT;
        held_control_next = held_control_reg;
        held_kind_next    = held_kind_reg;
        frame_ok_next     = 1'b0;
        control_code_next = '0;
        code_kind_next    = KIND_READY0;
        timed_out_next    = 1'b0;

        if (abort)
        begin
            held_control_next = '0;
            held_kind_next    = KIND_READY0;
            control_code_next = TIMEOUT_CODE;
            timed_out_next    = 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_ADDRESS:
                begin
                    if (rx_byte == address_reg)
                        state_next = ST_CONTROL;
                    else if (rx_byte == flag_reg)
                        state_next = ST_ADDRESS;
                end
                ST_CONTROL:
                begin
                    if (match.hit)
                    begin
                        held_control_next = rx_byte;
                        held_kind_next    = match.kind;
                        state_next        = ST_CHECK;
                    end
                    else if (rx_byte == flag_reg)
                    begin
                        state_next = ST_ADDRESS;
                    end
                end
                ST_CHECK:
                begin
                    if (rx_byte == (address_reg ^ held_control_reg))
                        state_next = ST_CLOSE;
                end
                ST_CLOSE:
                begin
                    if (rx_byte == flag_reg)
                    begin
                        frame_ok_next     = 1'b1;
                        control_code_next = held_control_reg;
                        code_kind_next    = held_kind_reg;
                    end
                end
                default:
                begin
                    // Flag hunting, and any unused state code.
                    if (rx_byte == flag_reg)
                        state_next = ST_ADDRESS;
                end
            endcase
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!in_stall)
            out_valid_reg <= in_valid;
    end

    // Result payload, loaded on each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            frame_ok_reg     <= frame_ok_next;
            control_code_reg <= control_code_next;
            code_kind_reg    <= code_kind_next;
            timed_out_reg    <= timed_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_ok     = frame_ok_reg;
    assign control_code = control_code_reg;
    assign code_kind    = code_kind_reg;
    assign timed_out    = timed_out_reg;

endmodule

`default_nettype wire

// ===== src/sfr_checker.sv =====
// Port-level checks for the supervisory frame receiver, bound to the top level.
`default_nettype none

module sfr_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input wire                 abort,
    input wire                 out_valid,
    input wire                 out_stall,
    input wire                 frame_ok,
    input wire sfr_pkg::byte_t control_code,
    input wire sfr_pkg::kind_t code_kind,
    input wire                 timed_out
);
    import sfr_pkg::*;

    // A stalled result stays on the channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // An accepted abort yields a timeout result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && abort |=> out_valid && timed_out)
        else $error("abort transfer did not produce a timeout");

    // A timeout result carries the timeout code and no frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> !frame_ok && control_code == TIMEOUT_CODE
            && code_kind == KIND_READY0)
        else $error("timeout result has wrong payload");

    // A completed frame reports one of the five code kinds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_ok |-> code_kind <= KIND_DISCONNECT)
        else $error("frame result has invalid code kind");

endmodule

bind supervisory_frame_receiver sfr_checker u_sfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .abort        (abort),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_ok     (frame_ok),
    .control_code (control_code),
    .code_kind    (code_kind),
    .timed_out    (timed_out)
);

`default_nettype wire
